// File: hw/rtl/vtrd_pkg.sv
package vtrd_pkg;

	localparam logic [31:0] SYNC_WORD  = 32'h3031_6364;
	localparam int          HOLD_LO    = 4;
	localparam int          HOLD_DEPTH = 20;

	typedef enum logic [2:0] {
		PH_SEARCH = 3'b001,
		PH_HEADER = 3'b010,
		PH_BODY   = 3'b100
	} phase_t;

	typedef enum logic [1:0] {
		SRC_IN,
		SRC_HOLD,
		SRC_CUR
	} src_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_PROC,
		OP_EMIT_HOLD,
		OP_BODY,
		OP_SEARCH_RST
	} op_t;

	typedef enum logic [1:0] {
		PTR_KEEP,
		PTR_ZERO,
		PTR_FOUR,
		PTR_INC
	} ptr_op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NOT_TYPE,
		C_BAD,
		C_DUMP_MORE,
		C_SCAN_MORE
	} cond_t;

	typedef logic [2:0] step_t;

	localparam step_t ST_IDLE      = 3'd0;
	localparam step_t ST_DISPATCH  = 3'd1;
	localparam step_t ST_DUMP      = 3'd2;
	localparam step_t ST_TAIL      = 3'd3;
	localparam step_t ST_SCAN_INIT = 3'd4;
	localparam step_t ST_SCAN      = 3'd5;
	localparam step_t ST_RETURN    = 3'd6;

	typedef struct packed {
		logic    accept;
		logic    wait_out;
		src_t    src;
		op_t     op;
		ptr_op_t ptr_op;
		cond_t   cond;
		step_t   target;
	} ctrl_t;

	typedef struct packed {
		logic at_type;
		logic type_bad;
		logic dump_more;
		logic scan_more;
	} flags_t;

	typedef struct packed {
		logic        valid;
		logic [7:0]  data;
		logic        first;
		logic        last;
		logic [2:0]  ptype;
		logic [15:0] length;
		logic [5:0]  offset;
	} emit_t;

	function automatic ctrl_t ucode(input step_t pc);
		ctrl_t w;
		w = '{accept: 1'b0, wait_out: 1'b0, src: SRC_IN, op: OP_NONE,
			ptr_op: PTR_KEEP, cond: C_ALWAYS, target: ST_IDLE};
		unique case (pc)
			ST_IDLE: begin
				w.accept = 1'b1;
				w.op     = OP_PROC;
				w.ptr_op = PTR_ZERO;
				w.cond   = C_NOT_TYPE;
				w.target = ST_IDLE;
			end
			ST_DISPATCH: begin
				w.cond   = C_BAD;
				w.target = ST_SCAN_INIT;
			end
			ST_DUMP: begin
				w.wait_out = 1'b1;
				w.op       = OP_EMIT_HOLD;
				w.ptr_op   = PTR_INC;
				w.cond     = C_DUMP_MORE;
				w.target   = ST_DUMP;
			end
			ST_TAIL: begin
				w.wait_out = 1'b1;
				w.src      = SRC_CUR;
				w.op       = OP_BODY;
			end
			ST_SCAN_INIT: begin
				w.op     = OP_SEARCH_RST;
				w.ptr_op = PTR_FOUR;
				w.cond   = C_NEVER;
			end
			ST_SCAN: begin
				w.src    = SRC_HOLD;
				w.op     = OP_PROC;
				w.ptr_op = PTR_INC;
				w.cond   = C_SCAN_MORE;
				w.target = ST_SCAN;
			end
			ST_RETURN: begin
				w.cond = C_ALWAYS;
			end
			default: begin
				w.cond = C_ALWAYS;
			end
		endcase
		return w;
	endfunction

	function automatic logic [4:0] type_pos(input logic ver);
		return ver ? 5'd19 : 5'd15;
	endfunction

	function automatic logic [5:0] header_size(input logic [2:0] t, input logic ver);
		logic [5:0] base;
		if (t <= 3'd2) begin
			base = 6'd30;
		end else if (t == 3'd3) begin
			base = 6'd26;
		end else begin
			base = 6'd18;
		end
		return base + (ver ? 6'd4 : 6'd0);
	endfunction

	function automatic logic [7:0] sync_byte(input logic [1:0] i);
		logic [7:0] b;
		case (i)
			2'd0:    b = SYNC_WORD[31:24];
			2'd1:    b = SYNC_WORD[23:16];
			2'd2:    b = SYNC_WORD[15:8];
			default: b = SYNC_WORD[7:0];
		endcase
		return b;
	endfunction

	function automatic logic [7:0] prefix_byte(input logic [1:0] i);
		logic [7:0] b;
		case (i)
			2'd0:    b = 8'h00;
			2'd1:    b = 8'h01;
			2'd2:    b = 8'hA0;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// 16 is 1 mod 5, so the upper nibbles summed give the quotient by 16 mod 5
	function automatic logic rem80_is4(input logic [15:0] v);
		logic [5:0] s;
		logic       m5;
		s = 6'(v[15:12]) + 6'(v[11:8]) + 6'(v[7:4]);
		case (s) inside
			6'd0, 6'd5, 6'd10, 6'd15, 6'd20, 6'd25, 6'd30, 6'd35, 6'd40, 6'd45: m5 = 1'b1;
			default: m5 = 1'b0;
		endcase
		return m5 && (v[3:0] == 4'd4);
	endfunction

endpackage

// File: hw/rtl/video_terminal_rtp_deframer.sv
// Finds packets in a raw byte stream by the sync word 30 31 63 64 and forwards
// every packet byte as one item, the header bytes first, with first_flag on the
// opening sync byte and last_flag on the final byte, which also carries the
// packet type, the body length and the payload offset. Bytes outside a packet
// are dropped. layout_version picks the 2016 or 2019 header layout; writing it
// restarts the sync search. A small microcode program steps a single byte unit
// through sync-search, header and body bytes. On the byte that completes a header
// with a known type, the held header is played out through the output register
// one byte a cycle while the output is free; on a header with an unknown type,
// its held bytes from byte 4 on go back through the byte unit.
module video_terminal_rtp_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        first_flag,
	output logic        last_flag,
	output logic [2:0]  packet_type,
	output logic [15:0] body_length,
	output logic [5:0]  payload_offset,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        layout_version
);
	import vtrd_pkg::*;

	ctrl_t       ctrl;
	flags_t      flags;
	emit_t       emit;
	logic        go;
	logic        out_free;
	logic        in_fire;
	logic        cfg_fire;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        first_q;
	logic        last_q;
	logic [2:0]  type_q;
	logic [15:0] length_q;
	logic [5:0]  offset_q;

	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = ctrl.accept;
	assign in_ready  = ctrl.accept && out_free && !cfg_valid;
	assign in_fire   = in_valid && in_ready;
	assign cfg_fire  = cfg_valid && cfg_ready;

	vtrd_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.out_free (out_free),
		.flags    (flags),
		.ctrl     (ctrl),
		.go       (go)
	);

	vtrd_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.go         (go),
		.in_byte    (in_byte),
		.cfg_fire   (cfg_fire),
		.cfg_layout (layout_version),
		.flags      (flags),
		.emit       (emit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			out_byte_q <= emit.data;
			first_q    <= emit.first;
			last_q     <= emit.last;
			type_q     <= emit.ptype;
			length_q   <= emit.length;
			offset_q   <= emit.offset;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_byte       = out_byte_q;
	assign first_flag     = first_q;
	assign last_flag      = last_q;
	assign packet_type    = type_q;
	assign body_length    = length_q;
	assign payload_offset = offset_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid |-> out_free)
		else $error("item emitted over an untaken result");

endmodule

// File: hw/rtl/vtrd_sequencer.sv
module vtrd_sequencer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_fire,
	input  logic             out_free,
	input  vtrd_pkg::flags_t flags,
	output vtrd_pkg::ctrl_t  ctrl,
	output logic             go
);
	import vtrd_pkg::*;

	step_t pc_q;
	logic  jump;

	always_comb begin
		ctrl = ucode(pc_q);
		if (ctrl.accept) begin
			go = in_fire;
		end else if (ctrl.wait_out) begin
			go = out_free;
		end else begin
			go = 1'b1;
		end
	end

	always_comb begin
		unique case (ctrl.cond)
			C_NEVER:     jump = 1'b0;
			C_ALWAYS:    jump = 1'b1;
			C_NOT_TYPE:  jump = !flags.at_type;
			C_BAD:       jump = flags.type_bad;
			C_DUMP_MORE: jump = flags.dump_more;
			C_SCAN_MORE: jump = flags.scan_more;
			default:     jump = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else if (go) begin
			pc_q <= jump ? ctrl.target : pc_q + 3'd1;
		end
	end

endmodule

// File: hw/rtl/vtrd_datapath.sv
module vtrd_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  vtrd_pkg::ctrl_t  ctrl,
	input  logic             go,
	input  logic [7:0]       in_byte,
	input  logic             cfg_fire,
	input  logic             cfg_layout,
	output vtrd_pkg::flags_t flags,
	output vtrd_pkg::emit_t  emit
);
	import vtrd_pkg::*;

	logic        version_q;
	phase_t      phase_q;
	logic [31:0] window_q;
	logic [16:0] pos_q;
	logic [2:0]  type_q;
	logic [15:0] len_q;
	logic [2:0]  pm_q;
	logic [4:0]  ptr_q;
	logic [7:0]  cur_q;
	logic        bad_q;
	logic [7:0]  hold_q [HOLD_LO:HOLD_DEPTH-1];

	logic [4:0]  tp;
	logic [7:0]  hold_rd;
	logic [7:0]  b;
	logic        do_proc;
	logic        do_body;
	logic        do_dump;
	logic [31:0] win_new;
	logic        sync_hit;
	logic        pos_at_tp;
	logic        nib_bad;
	logic [5:0]  hs;
	logic [16:0] hs17;
	logic [15:0] len_new;
	logic        in_pfx;
	logic [1:0]  pfx_idx;
	logic [2:0]  pm_new;
	logic        is_last;
	logic [5:0]  offset;

	assign tp = type_pos(version_q);

	always_comb begin
		if (ptr_q < 5'(HOLD_LO) || ptr_q > 5'(HOLD_DEPTH - 1)) begin
			hold_rd = sync_byte(ptr_q[1:0]);
		end else begin
			hold_rd = hold_q[ptr_q];
		end
	end

	always_comb begin
		case (ctrl.src)
			SRC_HOLD: b = hold_rd;
			SRC_CUR:  b = cur_q;
			default:  b = in_byte;
		endcase
	end

	assign do_proc = go && (ctrl.op == OP_PROC);
	assign do_dump = go && (ctrl.op == OP_EMIT_HOLD);
	assign do_body = go && ((ctrl.op == OP_BODY) || ((ctrl.op == OP_PROC) && (phase_q == PH_BODY)));

	assign win_new   = {window_q[23:0], b};
	assign sync_hit  = (win_new == SYNC_WORD);
	assign pos_at_tp = (pos_q == 17'(tp));
	assign nib_bad   = (b[7:4] > 4'd4);

	assign hs   = header_size(type_q, version_q);
	assign hs17 = 17'(hs);

	always_comb begin
		len_new = len_q;
		if (pos_q == hs17 - 17'd2) begin
			len_new[15:8] = b;
		end
		if (pos_q == hs17 - 17'd1) begin
			len_new[7:0] = b;
		end
	end

	assign in_pfx  = (pos_q >= hs17) && (pos_q < hs17 + 17'd4);
	assign pfx_idx = 2'(pos_q - hs17);

	always_comb begin
		pm_new = pm_q;
		if (in_pfx && (pm_q == {1'b0, pfx_idx}) && (b == prefix_byte(pfx_idx))) begin
			pm_new = pm_q + 3'd1;
		end
	end

	assign is_last = (pos_q >= hs17 - 17'd1)
		&& (({1'b0, pos_q} + 18'd1) >= (18'(hs) + 18'(len_new)));
	assign offset = hs + ((rem80_is4(len_new) && (pm_new == 3'd4)) ? 6'd4 : 6'd0);

	assign flags.at_type   = (phase_q == PH_HEADER) && pos_at_tp;
	assign flags.type_bad  = bad_q;
	assign flags.dump_more = (ptr_q != tp - 5'd1);
	assign flags.scan_more = (ptr_q != tp);

	always_comb begin
		emit.valid  = do_dump || do_body;
		emit.data   = do_dump ? hold_rd : b;
		emit.first  = do_dump && (ptr_q == 5'd0);
		emit.last   = do_body && is_last;
		emit.ptype  = emit.last ? type_q : 3'd0;
		emit.length = emit.last ? len_new : 16'd0;
		emit.offset = emit.last ? offset : 6'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q <= 1'b0;
			phase_q   <= PH_SEARCH;
			window_q  <= '0;
			pos_q     <= '0;
			type_q    <= '0;
			len_q     <= '0;
			pm_q      <= '0;
			ptr_q     <= '0;
			bad_q     <= 1'b0;
		end else if (cfg_fire) begin
			version_q <= cfg_layout;
			phase_q   <= PH_SEARCH;
			window_q  <= '0;
			pos_q     <= '0;
			pm_q      <= '0;
		end else begin
			if (go) begin
				case (ctrl.ptr_op)
					PTR_ZERO: ptr_q <= '0;
					PTR_FOUR: ptr_q <= 5'(HOLD_LO);
					PTR_INC:  ptr_q <= ptr_q + 5'd1;
					default:  ptr_q <= ptr_q;
				endcase
			end
			if (do_body) begin
				len_q <= len_new;
				pm_q  <= pm_new;
				if (is_last) begin
					phase_q  <= PH_SEARCH;
					window_q <= '0;
					pos_q    <= '0;
					pm_q     <= '0;
				end else begin
					phase_q <= PH_BODY;
					pos_q   <= pos_q + 17'd1;
				end
			end else if (do_proc && (phase_q == PH_SEARCH)) begin
				window_q <= win_new;
				if (sync_hit) begin
					pos_q   <= 17'(HOLD_LO);
					phase_q <= PH_HEADER;
				end
			end else if (do_proc && (phase_q == PH_HEADER)) begin
				if (!pos_at_tp) begin
					pos_q <= pos_q + 17'd1;
				end else begin
					bad_q <= nib_bad;
					if (!nib_bad) begin
						type_q <= b[6:4];
						len_q  <= '0;
						pm_q   <= '0;
					end
				end
			end else if (go && (ctrl.op == OP_SEARCH_RST)) begin
				phase_q  <= PH_SEARCH;
				window_q <= '0;
				pos_q    <= '0;
				pm_q     <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_proc && (phase_q == PH_HEADER)) begin
			hold_q[pos_q[4:0]] <= b;
		end
		if (go && ctrl.accept) begin
			cur_q <= in_byte;
		end
	end

	a_header_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HEADER) |-> (pos_q >= 17'(HOLD_LO)) && (pos_q <= 17'(tp)))
		else $error("header position outside held range");

	a_dump_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		do_dump |-> (ptr_q < tp))
		else $error("header replay ran past type byte");

	a_first_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(emit.valid && emit.first) |-> (emit.data == SYNC_WORD[31:24]) && !emit.last)
		else $error("first item is not the opening sync byte");

endmodule

// File: verif/deframer_checker.sv
`timescale 1ns / 1ps

module deframer_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  out_byte,
	input  logic        first_flag,
	input  logic        last_flag,
	input  logic [2:0]  packet_type,
	input  logic [15:0] body_length,
	input  logic [5:0]  payload_offset,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        layout_version,
	output int          fail_count,
	output int          outstanding,
	output int          packet_count
);
	import vtrd_pkg::*;

	typedef struct packed {
		logic [7:0]  data;
		logic        first;
		logic        last;
		logic [2:0]  ptype;
		logic [15:0] length;
		logic [5:0]  offset;
	} pkt_byte_t;

	localparam logic [7:0] LEAD_IN [4] = '{8'h00, 8'h01, 8'hA0, 8'h00};

	logic        ver;
	logic [31:0] window;
	logic [7:0]  hold [HOLD_DEPTH];
	logic [16:0] pos;
	phase_t      phase;
	logic [2:0]  htype;
	logic [15:0] hlen;
	logic [2:0]  lead_hits;
	logic [7:0]  work_q [$];
	pkt_byte_t   expected_q [$];

	function automatic int hdr_len(input logic [2:0] t);
		int n;
		n = (t <= 3'd2) ? 30 : ((t == 3'd3) ? 26 : 18);
		return n + (ver ? 4 : 0);
	endfunction

	function automatic void restart_search();
		phase     = PH_SEARCH;
		window    = '0;
		pos       = '0;
		lead_hits = '0;
	endfunction

	function automatic void body_step(input logic [7:0] b);
		int         hs;
		int         p;
		int         fin;
		logic [5:0] off;
		pkt_byte_t  r;
		hs = hdr_len(htype);
		p  = pos;
		if (p == hs - 2) hlen[15:8] = b;
		if (p == hs - 1) hlen[7:0] = b;
		if (p >= hs && p < hs + 4) begin
			if (lead_hits == p - hs && b == LEAD_IN[p - hs]) lead_hits = lead_hits + 3'd1;
		end
		fin = hs + int'(hlen) - 1;
		r   = '{data: b, first: 1'b0, last: 1'b0, ptype: '0, length: '0, offset: '0};
		if (p >= hs - 1 && p >= fin) begin
			off = 6'(hs + ((hlen % 80 == 4 && lead_hits == 3'd4) ? 4 : 0));
			r.last   = 1'b1;
			r.ptype  = htype;
			r.length = hlen;
			r.offset = off;
			expected_q.push_back(r);
			restart_search();
			return;
		end
		expected_q.push_back(r);
		pos = pos + 17'd1;
	endfunction

	function automatic void take_byte(input logic [7:0] b);
		int        tp;
		int        top_i;
		int        i;
		logic [3:0] nib;
		pkt_byte_t r;
		case (phase)
			PH_SEARCH: begin
				window = {window[23:0], b};
				if (window == SYNC_WORD) begin
					hold[0] = SYNC_WORD[31:24];
					hold[1] = SYNC_WORD[23:16];
					hold[2] = SYNC_WORD[15:8];
					hold[3] = SYNC_WORD[7:0];
					pos     = 17'd4;
					phase   = PH_HEADER;
				end
			end
			PH_HEADER: begin
				tp = ver ? 19 : 15;
				hold[pos] = b;
				if (pos < tp) begin
					pos = pos + 17'd1;
				end else begin
					nib = hold[tp][7:4];
					if (nib > 4'd4) begin
						// rescan held bytes from byte 4 ahead of anything still queued
						top_i = (pos < HOLD_DEPTH) ? int'(pos) : HOLD_DEPTH - 1;
						for (i = top_i; i >= HOLD_LO; i--) work_q.push_front(hold[i]);
						restart_search();
					end else begin
						htype     = nib[2:0];
						hlen      = '0;
						lead_hits = '0;
						for (i = 0; i < tp; i++) begin
							r = '{data: hold[i], first: (i == 0), last: 1'b0,
								ptype: '0, length: '0, offset: '0};
							expected_q.push_back(r);
						end
						phase = PH_BODY;
						body_step(b);
					end
				end
			end
			default: begin
				body_step(b);
			end
		endcase
	endfunction

	function automatic void predict(input logic [7:0] b);
		logic [7:0] cur;
		work_q.delete();
		work_q.push_back(b);
		while (work_q.size() > 0) begin
			cur = work_q.pop_front();
			take_byte(cur);
		end
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pkt_byte_t want;
		if (!arst_n) begin
			ver          = 1'b0;
			htype        = '0;
			hlen         = '0;
			restart_search();
			expected_q.delete();
			fail_count   = 0;
			outstanding  = 0;
			packet_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				ver = layout_version;
				restart_search();
			end
			if (in_valid && in_ready) predict(in_byte);
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t ns: unexpected item, expected none, got byte %02h", $time,
						out_byte);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					check_field("out_byte", 16'(want.data), 16'(out_byte));
					check_field("first_flag", 16'(want.first), 16'(first_flag));
					check_field("last_flag", 16'(want.last), 16'(last_flag));
					check_field("packet_type", 16'(want.ptype), 16'(packet_type));
					check_field("body_length", want.length, body_length);
					check_field("payload_offset", 16'(want.offset), 16'(payload_offset));
					if (want.last) packet_count++;
				end
			end
			outstanding = expected_q.size();
		end
	end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import vtrd_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  in_byte;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  out_byte;
	logic        first_flag;
	logic        last_flag;
	logic [2:0]  packet_type;
	logic [15:0] body_length;
	logic [5:0]  payload_offset;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        layout_version;

	int          fail_count;
	int          outstanding;
	int          packet_count;

	logic        cur_ver;
	int          bytes_sent;
	int          cfg_writes;
	logic [7:0]  frame_bytes [$];

	video_terminal_rtp_deframer dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_byte        (in_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.first_flag     (first_flag),
		.last_flag      (last_flag),
		.packet_type    (packet_type),
		.body_length    (body_length),
		.payload_offset (payload_offset),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.layout_version (layout_version)
	);

	deframer_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_byte        (in_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.first_flag     (first_flag),
		.last_flag      (last_flag),
		.packet_type    (packet_type),
		.body_length    (body_length),
		.payload_offset (payload_offset),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.layout_version (layout_version),
		.fail_count     (fail_count),
		.outstanding    (outstanding),
		.packet_count   (packet_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("** video_terminal_rtp_deframer: FAILED **");
		$finish;
	end

	initial begin : sink
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 13);
			if (stall > 0) begin
				@(negedge clk);
				out_ready = 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = $urandom_range(0, 13);
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid = 1'b1;
		in_byte  = b;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	task automatic send_frame();
		foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
		frame_bytes.delete();
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic cfg_write(input logic v);
		@(negedge clk);
		cfg_valid      = 1'b1;
		layout_version = v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		cur_ver   = v;
		cfg_writes++;
	endtask

	task automatic push_sync();
		frame_bytes.push_back(SYNC_WORD[31:24]);
		frame_bytes.push_back(SYNC_WORD[23:16]);
		frame_bytes.push_back(SYNC_WORD[15:8]);
		frame_bytes.push_back(SYNC_WORD[7:0]);
	endtask

	// nest: wrap a packet whose byte at the outer type slot carries an unknown type
	task automatic append_packet(input int tnib, input int len, input bit lead,
		input bit nest);
		int         tp;
		int         hs;
		int         last_i;
		int         i;
		logic [7:0] b;
		tp = cur_ver ? 19 : 15;
		hs = ((tnib <= 2) ? 30 : ((tnib == 3) ? 26 : 18)) + (cur_ver ? 4 : 0);
		last_i = (tnib > 4) ? tp : hs - 1;
		if (nest) push_sync();
		push_sync();
		for (i = 4; i <= last_i; i++) begin
			if (i == tp) b = {4'(tnib), 4'($urandom_range(0, 15))};
			else if (nest && i == tp - 4)
				b = {4'($urandom_range(5, 15)), 4'($urandom_range(0, 15))};
			else if (i == hs - 2) b = 8'(len >> 8);
			else if (i == hs - 1) b = 8'(len);
			else b = 8'($urandom);
			frame_bytes.push_back(b);
		end
		if (tnib <= 4) begin
			for (i = 0; i < len; i++) begin
				case (i)
					0: b = lead ? 8'h00 : 8'($urandom);
					1: b = lead ? 8'h01 : 8'($urandom);
					2: b = lead ? 8'hA0 : 8'($urandom);
					3: b = lead ? 8'h00 : 8'($urandom);
					default: b = 8'($urandom);
				endcase
				frame_bytes.push_back(b);
			end
		end
	endtask

	task automatic append_noise();
		int n;
		n = $urandom_range(1, 6);
		repeat (n) begin
			if ($urandom_range(0, 3) == 0)
				frame_bytes.push_back(SYNC_WORD[8 * $urandom_range(0, 3) +: 8]);
			else frame_bytes.push_back(8'($urandom));
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_byte        = '0;
		cfg_valid      = 1'b0;
		layout_version = 1'b0;
		cur_ver        = 1'b0;
		bytes_sent     = 0;
		cfg_writes     = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		cfg_write(1'b0);
		frame_bytes = '{8'h00, 8'hFF, 8'h30, 8'h31, 8'h63};
		append_packet(0, 0, 0, 0);
		append_packet(3, 4, 1, 0);
		send_frame();

		// a sync word spanning the end of a packet must not count
		append_packet(4, 3, 0, 0);
		repeat (3) void'(frame_bytes.pop_back());
		frame_bytes.push_back(8'h30);
		frame_bytes.push_back(8'h31);
		frame_bytes.push_back(8'h63);
		frame_bytes.push_back(8'h64);
		append_packet(1, 0, 0, 1);
		append_packet(15, 0, 0, 0);
		send_frame();

		// drop a partial header on a layout write
		push_sync();
		repeat (4) frame_bytes.push_back(8'($urandom));
		send_frame();
		drain_results();
		cfg_write(1'b1);

		append_packet(2, 4, 1, 0);
		append_noise();
		append_packet(5, 0, 0, 0);
		send_frame();

		// drop a partial body on a layout write
		append_packet(4, 4, 0, 0);
		repeat (2) void'(frame_bytes.pop_back());
		send_frame();
		drain_results();
		cfg_write(1'b0);

		append_packet(4, 0, 0, 0);
		send_frame();

		drain_results();
		$display("Sent %0d stream bytes and checked %0d packets across %0d layout writes,",
			bytes_sent, packet_count, cfg_writes);
		$display("covering both layouts, all types, lead-in offsets, rescans and dropped frames.");
		if (fail_count == 0) begin
			$display("** video_terminal_rtp_deframer: PASSED **");
		end else begin
			$display("** video_terminal_rtp_deframer: FAILED **");
		end
		$finish;
	end

endmodule
